// File: rtl/rcl_pkg.sv
// shared constants and codes for the per-client request rate limiter
`default_nettype none

package rcl_pkg;

    // table sizes
    localparam int CLIENTS_DEF = 16;
    localparam int BANS_DEF    = 8;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 16;
    localparam int VERDICT_W = 3;
    localparam int TRACK_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    // register reset values
    localparam logic [CNT_W-1:0] SECOND_LIMIT_RST = 16'd20;
    localparam logic [CNT_W-1:0] MINUTE_LIMIT_RST = 16'd300;
    localparam logic [CNT_W-1:0] BAN_SECONDS_RST  = 16'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINUTE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAN_SECONDS  = 2'd2;

    // operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] V_ACCEPT    = 3'd0;
    localparam logic [VERDICT_W-1:0] V_BANNED    = 3'd1;
    localparam logic [VERDICT_W-1:0] V_NEW_BAN   = 3'd2;
    localparam logic [VERDICT_W-1:0] V_UNTRACKED = 3'd3;
    localparam logic [VERDICT_W-1:0] V_TICK_DONE = 3'd4;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // subtract with floor at zero
    function automatic logic [CNT_W-1:0] drain(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] amt);
        drain = (v > amt) ? v - amt : '0;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rcl_ffs.sv
// lowest free slot finder over a row of valid bits
`default_nettype none

module rcl_ffs
    import rcl_pkg::*;
#(
    parameter int N = CLIENTS_DEF,
    localparam int IW = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0]  used,
    output logic          found,
    output logic [IW-1:0] idx
);

    // scan from the top so the lowest free slot wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                found = 1'b1;
                idx   = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/per_client_request_rate_limiter.sv
// top level of the per-client request rate limiter with ban list
//
// channel  | dir | handshake         | contents
// s        | in  | s_tvalid/s_tready | tuser op, tdata addr/now/minute_drain
// m        | out | m_tvalid/m_tready | tdata verdict/counts/full/tracked
// cfg      | in  | cfg_we            | cfg_idx, cfg_data
//
// a request scans the ban table and then the client table, a tick the client table:
// both walk the one-read-port tables one entry a cycle
// a new word is taken while the previous result waits in the output register
// reset clears all valid bits and the client count and loads the config reset values
// a stalled output holds a new result in S_OUT until the previous word leaves
`default_nettype none

module per_client_request_rate_limiter
    import rcl_pkg::*;
#(
    parameter int CLIENTS = CLIENTS_DEF,
    parameter int BANS    = BANS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // client_addr[31:0], now_seconds[63:32], minute_drain[64], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // verdict[2:0], second_count[18:3], minute_count[34:19],
    // ban_table_full[35], tracked_clients[40:36], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CNT_W-1:0]      cfg_data
);

    localparam int CIW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int BIW  = (BANS > 1) ? $clog2(BANS) : 1;
    localparam int MAXN = (CLIENTS > BANS) ? CLIENTS : BANS;
    localparam int SCW  = $clog2(MAXN + 1);
    localparam int TCW  = $clog2(CLIENTS + 1);
    localparam int CM_W = ADDR_W + 2 * CNT_W;
    localparam int BM_W = ADDR_W + TIME_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BSCAN  = 3'd1;
    localparam logic [2:0] S_CSCAN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    // configuration registers
    logic [CNT_W-1:0] sec_lim_reg, min_lim_reg, ban_sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_lim_reg <= SECOND_LIMIT_RST;
            min_lim_reg <= MINUTE_LIMIT_RST;
            ban_sec_reg <= BAN_SECONDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SECOND_LIMIT: sec_lim_reg <= cfg_data;
                REG_MINUTE_LIMIT: min_lim_reg <= cfg_data;
                REG_BAN_SECONDS:  ban_sec_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // control state
    logic [2:0]         state_reg, state_next;
    logic [SCW-1:0]     scan_reg, scan_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [SCW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [CLIENTS-1:0] cvalid_reg, cvalid_next;
    logic [BANS-1:0]    bvalid_reg, bvalid_next;
    logic [TCW-1:0]     tcnt_reg, tcnt_next;
    logic               banned_reg, banned_next;
    logic               cfound_reg, cfound_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload state
    logic                 op_reg;
    logic                 mdrain_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [CIW-1:0]       cidx_reg, cidx_next;
    logic [CNT_W-1:0]     csc_reg, csc_next, cmc_reg, cmc_next;
    logic [VERDICT_W-1:0] verd_reg, verd_next;
    logic [CNT_W-1:0]     rsc_reg, rsc_next, rmc_reg, rmc_next;
    logic                 full_reg, full_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // memories
    logic [CM_W-1:0] cmem [CLIENTS];
    logic [BM_W-1:0] bmem [BANS];
    logic [CM_W-1:0] crd_reg;
    logic [BM_W-1:0] brd_reg;
    logic            cwe, bwe;
    logic [CIW-1:0]  cwa;
    logic [BIW-1:0]  bwa;
    logic [CM_W-1:0] cwd;
    logic [BM_W-1:0] bwd;

    always_ff @(posedge clk)
    begin
        crd_reg <= cmem[scan_reg[CIW-1:0]];
        brd_reg <= bmem[scan_reg[BIW-1:0]];
        if (cwe)
        begin
            cmem[cwa] <= cwd;
        end
        if (bwe)
        begin
            bmem[bwa] <= bwd;
        end
    end

    // free slot search
    logic           cfree_ok, bfree_ok;
    logic [CIW-1:0] cfree_idx;
    logic [BIW-1:0] bfree_idx;

    rcl_ffs #(.N(CLIENTS)) u_cfree (
        .used  (cvalid_reg),
        .found (cfree_ok),
        .idx   (cfree_idx)
    );

    rcl_ffs #(.N(BANS)) u_bfree (
        .used  (bvalid_reg),
        .found (bfree_ok),
        .idx   (bfree_idx)
    );

    // read data fields
    logic [ADDR_W-1:0] c_addr, b_addr;
    logic [CNT_W-1:0]  c_sc, c_mc;
    logic [TIME_W-1:0] b_rel;
    assign c_addr = crd_reg[ADDR_W-1:0];
    assign c_sc   = crd_reg[ADDR_W+CNT_W-1:ADDR_W];
    assign c_mc   = crd_reg[CM_W-1:ADDR_W+CNT_W];
    assign b_addr = brd_reg[ADDR_W-1:0];
    assign b_rel  = brd_reg[BM_W-1:ADDR_W];

    // scan bookkeeping
    logic [SCW-1:0] scan_lim;
    logic           issue, scan_done;
    logic [CIW-1:0] cmp_c;
    logic [BIW-1:0] cmp_b;
    assign scan_lim  = (state_reg == S_BSCAN) ? SCW'(BANS) : SCW'(CLIENTS);
    assign issue     = scan_reg < scan_lim;
    assign scan_done = !issue && !cmp_vld_reg;
    assign cmp_c     = cmp_idx_reg[CIW-1:0];
    assign cmp_b     = cmp_idx_reg[BIW-1:0];

    // decide datapath
    logic [CNT_W-1:0]  inc_sc, inc_mc, dr_sc, dr_mc;
    logic [TIME_W:0]   rel_sum;
    logic [TIME_W-1:0] rel_time;
    assign inc_sc   = cfound_reg ? sat_inc(csc_reg) : CNT_W'(1);
    assign inc_mc   = cfound_reg ? sat_inc(cmc_reg) : CNT_W'(1);
    assign dr_sc    = drain(c_sc, sec_lim_reg);
    assign dr_mc    = mdrain_reg ? drain(c_mc, min_lim_reg) : c_mc;
    assign rel_sum  = {1'b0, now_reg} + {{(TIME_W+1-CNT_W){1'b0}}, ban_sec_reg};
    assign rel_time = rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = scan_reg;
        cvalid_next   = cvalid_reg;
        bvalid_next   = bvalid_reg;
        tcnt_next     = tcnt_reg;
        banned_next   = banned_reg;
        cfound_next   = cfound_reg;
        cidx_next     = cidx_reg;
        csc_next      = csc_reg;
        cmc_next      = cmc_reg;
        verd_next     = verd_reg;
        rsc_next      = rsc_reg;
        rmc_next      = rmc_reg;
        full_next     = full_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        cwe = 1'b0;
        cwa = cmp_c;
        cwd = '0;
        bwe = 1'b0;
        bwa = bfree_idx;
        bwd = {rel_time, addr_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                scan_next   = '0;
                banned_next = 1'b0;
                cfound_next = 1'b0;
                full_next   = 1'b0;
                if (s_tvalid)
                begin
                    state_next = (s_tuser == OP_TICK) ? S_TICK : S_BSCAN;
                end
            end
            S_BSCAN:
            begin
                if (issue)
                begin
                    scan_next    = scan_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                // one valid ban entry at most matches an address
                if (cmp_vld_reg && bvalid_reg[cmp_b] && b_addr == addr_reg)
                begin
                    if (now_reg < b_rel)
                    begin
                        banned_next = 1'b1;
                    end
                    else
                    begin
                        bvalid_next[cmp_b] = 1'b0;
                    end
                end
                if (scan_done)
                begin
                    scan_next  = '0;
                    state_next = S_CSCAN;
                end
            end
            S_CSCAN:
            begin
                if (issue)
                begin
                    scan_next    = scan_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                if (cmp_vld_reg && cvalid_reg[cmp_c] && c_addr == addr_reg)
                begin
                    cfound_next = 1'b1;
                    cidx_next   = cmp_c;
                    csc_next    = c_sc;
                    cmc_next    = c_mc;
                end
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                if (banned_reg)
                begin
                    verd_next = V_BANNED;
                    rsc_next  = cfound_reg ? csc_reg : '0;
                    rmc_next  = cfound_reg ? cmc_reg : '0;
                end
                else if (!cfound_reg && !cfree_ok)
                begin
                    verd_next = V_UNTRACKED;
                    rsc_next  = '0;
                    rmc_next  = '0;
                end
                else
                begin
                    // bump an existing client or open a new one
                    cwe      = 1'b1;
                    cwa      = cfound_reg ? cidx_reg : cfree_idx;
                    cwd      = {inc_mc, inc_sc, addr_reg};
                    rsc_next = inc_sc;
                    rmc_next = inc_mc;
                    if (!cfound_reg)
                    begin
                        cvalid_next[cfree_idx] = 1'b1;
                        tcnt_next = tcnt_reg + 1'b1;
                    end
                    verd_next = V_ACCEPT;
                    if (inc_sc > sec_lim_reg || inc_mc > min_lim_reg)
                    begin
                        verd_next = V_NEW_BAN;
                        if (bfree_ok)
                        begin
                            bwe = 1'b1;
                            bvalid_next[bfree_idx] = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                end
            end
            S_TICK:
            begin
                if (issue)
                begin
                    scan_next    = scan_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                // drain one entry a cycle, free it when both counts reach zero
                if (cmp_vld_reg && cvalid_reg[cmp_c])
                begin
                    cwe = 1'b1;
                    cwa = cmp_c;
                    cwd = {dr_mc, dr_sc, c_addr};
                    if (dr_sc == '0 && dr_mc == '0)
                    begin
                        cvalid_next[cmp_c] = 1'b0;
                        tcnt_next = tcnt_reg - 1'b1;
                    end
                end
                if (scan_done)
                begin
                    verd_next  = V_TICK_DONE;
                    rsc_next   = '0;
                    rmc_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_DATA_W-41){1'b0}}, TRACK_W'(tcnt_reg),
                                     full_reg, rmc_reg, rsc_reg, verd_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            cvalid_reg   <= '0;
            bvalid_reg   <= '0;
            tcnt_reg     <= '0;
            banned_reg   <= 1'b0;
            cfound_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            cvalid_reg   <= cvalid_next;
            bvalid_reg   <= bvalid_next;
            tcnt_reg     <= tcnt_next;
            banned_reg   <= banned_next;
            cfound_reg   <= cfound_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg     <= s_tuser;
            addr_reg   <= s_tdata[ADDR_W-1:0];
            now_reg    <= s_tdata[ADDR_W+TIME_W-1:ADDR_W];
            mdrain_reg <= s_tdata[ADDR_W+TIME_W];
        end
        cidx_reg    <= cidx_next;
        csc_reg     <= csc_next;
        cmc_reg     <= cmc_next;
        verd_reg    <= verd_next;
        rsc_reg     <= rsc_next;
        rmc_reg     <= rmc_next;
        full_reg    <= full_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // client count tracks the valid bits
    a_tcnt: assert property (@(posedge clk) disable iff (!rst_n)
        tcnt_reg == TCW'($countones(cvalid_reg)))
        else $error("client count out of step with valid bits");

    // an accepted word starts the matching scan
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> (op_reg == OP_TICK && state_reg == S_TICK) ||
                                 (op_reg == OP_REQUEST && state_reg == S_BSCAN))
        else $error("accepted word did not start its scan");

    // compare stage only runs inside a scan
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> state_reg == S_BSCAN || state_reg == S_CSCAN ||
                        state_reg == S_TICK)
        else $error("compare stage active outside a scan");

endmodule

`default_nettype wire

// File: verif/tb_per_client_request_rate_limiter.sv
// self-checking testbench for the per-client request rate limiter with ban list
`default_nettype none

module tb_per_client_request_rate_limiter;
    import rcl_pkg::*;

    localparam int NCLI = 16;
    localparam int NBAN = 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic                 op;
        logic [ADDR_W-1:0]    addr;
        logic [TIME_W-1:0]    now;
        logic                 mdrain;
    } req_word_t;

    // fields from the highest bit down, so verdict lands in the lowest bits
    typedef struct packed {
        logic [TRACK_W-1:0]   tracked;
        logic                 ban_full;
        logic [CNT_W-1:0]     min_cnt;
        logic [CNT_W-1:0]     sec_cnt;
        logic [VERDICT_W-1:0] verdict;
    } verdict_word_t;

    // directed row: word plus optional typed-in result
    typedef struct {
        req_word_t     w;
        bit            fixed;
        verdict_word_t res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CNT_W-1:0]      cfg_data;

    per_client_request_rate_limiter uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    // shadow state of the limiter
    logic [ADDR_W-1:0] cli_addr [NCLI];
    bit                cli_ok   [NCLI];
    logic [CNT_W-1:0]  cli_sec  [NCLI];
    logic [CNT_W-1:0]  cli_min  [NCLI];
    logic [ADDR_W-1:0] ban_addr [NBAN];
    bit                ban_ok   [NBAN];
    logic [TIME_W-1:0] ban_until[NBAN];
    logic [CNT_W-1:0]  lim_sec, lim_min, ban_len;

    verdict_word_t pending_verdicts[$];
    int  errors = 0;
    int  cycles = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  bans_seen = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    // pool of addresses so clients repeat and get banned
    logic [ADDR_W-1:0] addr_pool[24];
    logic [TIME_W-1:0] clock_now;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk) cycles <= cycles + 1;

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("per_client_request_rate_limiter test failed");
            $finish;
        end
    end

    function automatic verdict_word_t limiter_step(req_word_t w);
        verdict_word_t r;
        bit still_banned;
        int c;
        int slot;
        logic [TIME_W:0] rel;
        int n;
        r = '0;
        if (w.op == OP_TICK)
        begin
            for (int i = 0; i < NCLI; i++)
            begin
                if (!cli_ok[i]) continue;
                cli_sec[i] = (cli_sec[i] > lim_sec) ? cli_sec[i] - lim_sec : '0;
                if (w.mdrain)
                    cli_min[i] = (cli_min[i] > lim_min) ? cli_min[i] - lim_min : '0;
                if (cli_sec[i] == 0 && cli_min[i] == 0) cli_ok[i] = 0;
            end
            r.verdict = V_TICK_DONE;
        end
        else
        begin
            still_banned = 0;
            for (int b = 0; b < NBAN; b++)
            begin
                if (ban_ok[b] && ban_addr[b] == w.addr)
                begin
                    if (w.now < ban_until[b]) still_banned = 1;
                    else ban_ok[b] = 0;
                    break;
                end
            end
            c = -1;
            for (int i = 0; i < NCLI; i++)
                if (c < 0 && cli_ok[i] && cli_addr[i] == w.addr) c = i;
            if (still_banned)
            begin
                r.verdict = V_BANNED;
                if (c >= 0)
                begin
                    r.sec_cnt = cli_sec[c];
                    r.min_cnt = cli_min[c];
                end
            end
            else
            begin
                if (c >= 0)
                begin
                    if (cli_sec[c] != 16'hFFFF) cli_sec[c] = cli_sec[c] + 1'b1;
                    if (cli_min[c] != 16'hFFFF) cli_min[c] = cli_min[c] + 1'b1;
                end
                else
                begin
                    for (int i = 0; i < NCLI; i++)
                    begin
                        if (!cli_ok[i])
                        begin
                            c = i;
                            cli_ok[i] = 1;
                            cli_addr[i] = w.addr;
                            cli_sec[i] = 16'd1;
                            cli_min[i] = 16'd1;
                            break;
                        end
                    end
                end
                if (c < 0)
                    r.verdict = V_UNTRACKED;
                else
                begin
                    r.verdict = V_ACCEPT;
                    r.sec_cnt = cli_sec[c];
                    r.min_cnt = cli_min[c];
                    if (cli_sec[c] > lim_sec || cli_min[c] > lim_min)
                    begin
                        r.verdict = V_NEW_BAN;
                        rel = {1'b0, w.now} + {17'd0, ban_len};
                        if (rel[TIME_W]) rel = {1'b0, 32'hFFFF_FFFF};
                        slot = -1;
                        for (int b = 0; b < NBAN; b++)
                            if (slot < 0 && !ban_ok[b]) slot = b;
                        if (slot < 0)
                            r.ban_full = 1'b1;
                        else
                        begin
                            ban_ok[slot] = 1;
                            ban_addr[slot] = w.addr;
                            ban_until[slot] = rel[TIME_W-1:0];
                        end
                    end
                end
            end
        end
        n = 0;
        for (int i = 0; i < NCLI; i++) n += cli_ok[i];
        r.tracked = n[TRACK_W-1:0];
        return r;
    endfunction

    // send one word, waiting out the handshake
    task automatic send_word(req_word_t w, bit fixed, verdict_word_t res);
        verdict_word_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        pred = limiter_step(w);
        if (fixed && pred !== res)
        begin
            $display("%0t: table row disagrees with prediction: expected %h actual %h",
                     $time, res, pred);
            errors++;
        end
        pending_verdicts.push_back(fixed ? res : pred);
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {7'd0, w.mdrain, w.now, w.addr};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SECOND_LIMIT: lim_sec = val;
            REG_MINUTE_LIMIT: lim_min = val;
            default:          ban_len = val;
        endcase
    endtask

    // wait for all results, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (NBAN + NCLI + 10) @(posedge clk);
    endtask

    // receiver: random stalls, compare each word
    always @(posedge clk)
    begin
        verdict_word_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[40:0];
                words_seen++;
                if (got.verdict == V_NEW_BAN) bans_seen++;
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.verdict !== want.verdict)
                    begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, got.verdict);
                        errors++;
                    end
                    if (got.sec_cnt !== want.sec_cnt)
                    begin
                        $display("%0t: second_count expected %0d actual %0d",
                                 $time, want.sec_cnt, got.sec_cnt);
                        errors++;
                    end
                    if (got.min_cnt !== want.min_cnt)
                    begin
                        $display("%0t: minute_count expected %0d actual %0d",
                                 $time, want.min_cnt, got.min_cnt);
                        errors++;
                    end
                    if (got.ban_full !== want.ban_full)
                    begin
                        $display("%0t: ban_table_full expected %0d actual %0d",
                                 $time, want.ban_full, got.ban_full);
                        errors++;
                    end
                    if (got.tracked !== want.tracked)
                    begin
                        $display("%0t: tracked_clients expected %0d actual %0d",
                                 $time, want.tracked, got.tracked);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic req_word_t make_req(logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t);
        req_word_t w;
        w.op = OP_REQUEST;
        w.addr = a;
        w.now = t;
        w.mdrain = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic req_word_t make_tick(logic [TIME_W-1:0] t, bit md);
        req_word_t w;
        w.op = OP_TICK;
        w.addr = $urandom();
        w.now = t;
        w.mdrain = md;
        return w;
    endfunction

    function automatic verdict_word_t res_of(logic [VERDICT_W-1:0] v, int sc, int mc,
                                             bit full, int trk);
        verdict_word_t r;
        r.verdict = v;
        r.sec_cnt = CNT_W'(sc);
        r.min_cnt = CNT_W'(mc);
        r.ban_full = full;
        r.tracked = TRACK_W'(trk);
        return r;
    endfunction

    // one random phase of well-formed traffic with noise
    task automatic random_phase(int n_words, int pool_size);
        req_word_t w;
        for (int k = 0; k < n_words; k++)
        begin
            clock_now = clock_now + $urandom_range(1);
            case ($urandom_range(19))
                0, 1: w = make_tick(clock_now, 1'($urandom_range(1)));
                2:    w = make_req($urandom(), $urandom());
                3:    w = make_req(addr_pool[$urandom_range(pool_size - 1)], $urandom());
                default:
                    w = make_req(addr_pool[$urandom_range(pool_size - 1)], clock_now);
            endcase
            send_word(w, 0, '0);
        end
    endtask

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_REQUEST;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_SECOND_LIMIT;
        cfg_data = '0;
        lim_sec = SECOND_LIMIT_RST;
        lim_min = MINUTE_LIMIT_RST;
        ban_len = BAN_SECONDS_RST;
        for (int i = 0; i < NCLI; i++) cli_ok[i] = 0;
        for (int b = 0; b < NBAN; b++) ban_ok[b] = 0;
        for (int i = 0; i < 24; i++) addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        clock_now = 32'd1000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: reset defaults, extremes, tick
        row.fixed = 1; row.w = make_req(32'h0, 32'h0);
        row.res = res_of(V_ACCEPT, 1, 1, 0, 1); rows.push_back(row);
        row.w = make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row.res = res_of(V_ACCEPT, 1, 1, 0, 2); rows.push_back(row);
        row.w = make_tick(32'h0, 1);
        row.res = res_of(V_TICK_DONE, 0, 0, 0, 0); rows.push_back(row);
        foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].res);
        drain_results();

        // limit 1: second request bans; saturating release time; ban_seconds 0
        write_reg(REG_SECOND_LIMIT, 16'd1);
        write_reg(REG_BAN_SECONDS, 16'hFFFF);
        send_word(make_req(32'hA, 32'hFFFF_FFF0), 1, res_of(V_ACCEPT, 1, 1, 0, 1));
        send_word(make_req(32'hA, 32'hFFFF_FFF0), 1, res_of(V_NEW_BAN, 2, 2, 0, 1));
        send_word(make_req(32'hA, 32'hFFFF_FFFE), 1, res_of(V_BANNED, 2, 2, 0, 1));
        // fill the ban table, then overflow it
        for (int b = 0; b < NBAN; b++)
        begin
            send_word(make_req(32'h100 + b, 32'd5), 0, '0);
            send_word(make_req(32'h100 + b, 32'd5), 0, '0);
        end
        send_word(make_req(32'hA, 32'hFFFF_FFFF), 0, '0);
        drain_results();
        write_reg(REG_BAN_SECONDS, 16'd0);
        send_word(make_tick(32'd6, 1), 0, '0);
        send_word(make_tick(32'd6, 1), 0, '0);
        drain_results();

        // fill the client table to reach untracked requests
        write_reg(REG_SECOND_LIMIT, 16'hFFFF);
        write_reg(REG_MINUTE_LIMIT, 16'hFFFF);
        for (int i = 0; i < NCLI + 2; i++) send_word(make_req(32'h200 + i, 32'd7), 0, '0);
        send_word(make_tick(32'd8, 0), 0, '0);
        drain_results();
        write_reg(REG_SECOND_LIMIT, 16'hFFFF);
        send_word(make_tick(32'd9, 1), 0, '0);
        send_word(make_tick(32'd9, 1), 0, '0);
        drain_results();

        // random phases, each with its own register setting and an idling mix
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 36; recv_stall_pct = 36; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_reg(REG_SECOND_LIMIT,
                      (ph == 4) ? 16'hFFFF : CNT_W'($urandom_range(1, 6)));
            write_reg(REG_MINUTE_LIMIT,
                      (ph == 1) ? 16'd1 : CNT_W'($urandom_range(2, 40)));
            write_reg(REG_BAN_SECONDS,
                      (ph == 2) ? 16'hFFFF : CNT_W'($urandom_range(1, 8)));
            random_phase(100, (ph == 3) ? 24 : 12);
            drain_results();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (NBAN + NCLI + 10) @(posedge clk);

        $display("sent %0d words, checked %0d results, %0d of them new bans",
                 words_sent, words_seen, bans_seen);
        $display("covered reset defaults, limit extremes, full tables and idle/stall mixes");
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("per_client_request_rate_limiter test passed");
        else
            $display("per_client_request_rate_limiter test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/rcl_pkg.sv
rtl/rcl_ffs.sv
rtl/per_client_request_rate_limiter.sv
verif/tb_per_client_request_rate_limiter.sv
